>>> hw/rtl/rpl_pkg.sv
package rpl_pkg;

   typedef enum logic [1:0] {
      ACT_REGISTER  = 2'd0,
      ACT_HEARTBEAT = 2'd1,
      ACT_TICK      = 2'd2,
      ACT_PLACE     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK          = 2'd0,
      STAT_FULL        = 2'd1,
      STAT_NO_LIVE     = 2'd2,
      STAT_NONE_FAILED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_WALK,
      S_TICK_RD,
      S_TICK_WR,
      S_TICK_DONE,
      S_TICK_EMIT
   } state_type;

   // register index as decoded from the csr address
   localparam logic REG_REPL_FACTOR = 1'b0;
   localparam logic REG_DEAD_LIMIT  = 1'b1;

   // node ids and ranks travel in 4-bit and 3-bit fields
   localparam int MAX_NODES    = 16;
   localparam int MAX_REPLICAS = 8;

   localparam int RESULT_CAP      = 16;
   localparam int KEY_W           = 32;
   localparam logic [3:0] RF_RST  = 4'd1;
   localparam logic [7:0] DL_RST  = 8'd10;
   localparam logic [7:0] AGE_MAX = 8'hff;

endpackage

>>> hw/rtl/rpl_divmod.sv
module rpl_divmod #(
   parameter int DW = 32,
   parameter int VW = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [VW-1:0] remainder
);

   localparam int NW = $clog2(DW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [NW-1:0] cnt_ff;
   logic [DW-1:0] quo_ff;
   logic [VW-1:0] rem_ff;

   logic [VW:0] trial;
   logic [VW:0] diff;
   logic        ge;

   // restoring remainder, one dividend bit a cycle
   assign trial = {rem_ff, quo_ff[DW-1]};
   assign ge    = trial >= {1'b0, divisor};
   assign diff  = trial - {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= NW'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - NW'(1);
            if (cnt_ff == NW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= quo_ff << 1;
         rem_ff <= ge ? diff[VW-1:0] : trial[VW-1:0];
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> hw/rtl/replica_placement_with_liveness_unit.sv
// Keeps a table of MAX_NODES storage nodes (alive bits in flops, heartbeat ages in a
// synchronous memory) and serves four actions arriving on req: register, heartbeat,
// tick and place; results leave on rsp, one beat per result, rsp_tlast on the last
// beat of an action. Register and heartbeat answer from the idle state with a single
// beat. Tick walks the age memory, reading then writing back the age of each live node
// and passing over each other entry, then checks for failures; with failures it walks
// again from id 0 up to the last failed node, one entry a cycle while rsp is not
// stalled, each failed node giving one beat. Place runs a bit-serial remainder of
// key_hash by the live count, then walks the alive bits from id 0, wrapping, one entry
// a cycle while rsp is not stalled, emitting one beat per replica. One action is in
// flight at a time; a new one is taken once the last beat of the previous one has left
// the output register or leaves it in that cycle. No clearing pass is needed after reset.
module replica_placement_with_liveness_unit
   import rpl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // config port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // node_id[3:0], key_hash[35:4], zero pad
   input  logic [1:0]  req_tuser,  // action[1:0]
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // result_node[3:0], replica_rank[6:4], live_count[11:7]
   output logic [1:0]  rsp_tuser,  // status[1:0]
   output logic        rsp_tlast
);

   localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int RW = $clog2(MAX_REPLICAS + 1);

   state_type state_ff, state_in;

   logic [IW-1:0]        ptr_ff, ptr_in;
   logic [CW-1:0]        skip_ff, skip_in;
   logic [RW-1:0]        rank_ff, rank_in;
   logic [RW-1:0]        want_ff, want_in;
   logic [3:0]           emit_cnt_ff, emit_cnt_in;
   logic [MAX_NODES-1:0] alive_ff, alive_in;
   logic [MAX_NODES-1:0] failed_ff, failed_in;
   logic [CW-1:0]        live_cnt_ff, live_cnt_in;
   logic [CW-1:0]        next_free_ff, next_free_in;
   logic [3:0]           rf_ff;
   logic [7:0]           dl_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [3:0] rsp_node_ff, rsp_node_in;
   logic [2:0] rsp_rank_ff, rsp_rank_in;
   logic [4:0] rsp_live_ff, rsp_live_in;
   logic       rsp_last_ff, rsp_last_in;

   // age memory
   logic [7:0]    age_mem [MAX_NODES];
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic [IW-1:0] mem_raddr;
   logic [7:0]    mem_q_ff;

   logic          div_start;
   logic          div_done;
   logic [CW-1:0] div_rem;

   logic          csr_wr;
   logic          out_free;
   logic          req_fire;
   action_type    req_action;
   logic [3:0]    req_node;
   logic [KEY_W-1:0] req_key;

   logic [IW-1:0]        hb_idx;
   logic                 hb_in_range;
   logic [CW-1:0]        live_p1;
   logic [6:0]           want_calc;
   logic [7:0]           age_next;
   logic                 ptr_last;
   logic [IW-1:0]        ptr_wrap;
   logic [MAX_NODES-1:0] above_mask;
   logic                 more_failed;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_DEAD_LIMIT) ? {24'd0, dl_ff} : {28'd0, rf_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_ff <= RF_RST;
         dl_ff <= DL_RST;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_DEAD_LIMIT) begin
            dl_ff <= csr_pwdata[7:0];
         end else begin
            rf_ff <= csr_pwdata[3:0];
         end
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign req_action = action_type'(req_tuser);
   assign req_node   = req_tdata[3:0];
   assign req_key    = req_tdata[35:4];

   assign hb_idx      = IW'(req_node);
   assign hb_in_range = {3'd0, req_node} < 7'(MAX_NODES);
   assign live_p1     = live_cnt_ff + CW'(1);
   assign age_next    = (mem_q_ff == AGE_MAX) ? AGE_MAX : mem_q_ff + 8'd1;
   assign ptr_last    = ptr_ff == IW'(MAX_NODES - 1);
   assign ptr_wrap    = ptr_last ? '0 : ptr_ff + IW'(1);

   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         above_mask[i] = IW'(i) > ptr_ff;
      end
   end
   assign more_failed = |(failed_ff & above_mask);

   // replica count: factor (zero as one), capped by live nodes, replicas and beats
   always_comb begin
      want_calc = (rf_ff == 4'd0) ? 7'd1 : {3'd0, rf_ff};
      if (7'(live_cnt_ff) < want_calc) want_calc = 7'(live_cnt_ff);
      if (7'(MAX_REPLICAS) < want_calc) want_calc = 7'(MAX_REPLICAS);
      if (7'(RESULT_CAP) < want_calc) want_calc = 7'(RESULT_CAP);
   end

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      skip_in      = skip_ff;
      rank_in      = rank_ff;
      want_in      = want_ff;
      emit_cnt_in  = emit_cnt_ff;
      alive_in     = alive_ff;
      failed_in    = failed_ff;
      live_cnt_in  = live_cnt_ff;
      next_free_in = next_free_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_live_in   = rsp_live_ff;
      rsp_last_in   = rsp_last_ff;

      mem_we    = 1'b0;
      mem_waddr = ptr_ff;
      mem_wdata = 8'd0;
      mem_raddr = ptr_ff;
      div_start = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_node_in   = 4'd0;
               rsp_rank_in   = 3'd0;
               rsp_live_in   = 5'(live_cnt_ff);
               rsp_last_in   = 1'b1;
               unique case (req_action)
                  ACT_REGISTER: begin
                     if (next_free_ff >= CW'(MAX_NODES)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        mem_we      = 1'b1;
                        mem_waddr   = IW'(next_free_ff);
                        mem_wdata   = 8'd0;
                        alive_in[IW'(next_free_ff)] = 1'b1;
                        next_free_in = next_free_ff + CW'(1);
                        live_cnt_in  = live_p1;
                        rsp_node_in  = 4'(next_free_ff);
                        rsp_live_in  = 5'(live_p1);
                     end
                  end
                  ACT_HEARTBEAT: begin
                     rsp_node_in = req_node;
                     if (hb_in_range && alive_ff[hb_idx]) begin
                        mem_we    = 1'b1;
                        mem_waddr = hb_idx;
                        mem_wdata = 8'd0;
                     end
                  end
                  ACT_TICK: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_tready;
                     failed_in    = '0;
                     ptr_in       = '0;
                     state_in     = S_TICK_RD;
                  end
                  ACT_PLACE: begin
                     if (live_cnt_ff == '0) begin
                        rsp_status_in = STAT_NO_LIVE;
                     end else begin
                        rsp_valid_in = rsp_valid_ff && !rsp_tready;
                        div_start    = 1'b1;
                        want_in      = RW'(want_calc);
                        state_in     = S_DIV;
                     end
                  end
               endcase
            end
         end

         S_DIV: begin
            if (div_done) begin
               skip_in  = div_rem;
               ptr_in   = '0;
               rank_in  = '0;
               state_in = S_WALK;
            end
         end

         // skip remainder-many live nodes, then one beat per live node, wrapping
         S_WALK: begin
            if (!alive_ff[ptr_ff]) begin
               ptr_in = ptr_wrap;
            end else if (skip_ff != '0) begin
               skip_in = skip_ff - CW'(1);
               ptr_in  = ptr_wrap;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_node_in   = 4'(ptr_ff);
               rsp_rank_in   = 3'(rank_ff);
               rsp_live_in   = 5'(live_cnt_ff);
               rsp_last_in   = RW'(rank_ff + RW'(1)) == want_ff;
               rank_in       = rank_ff + RW'(1);
               ptr_in        = ptr_wrap;
               if (RW'(rank_ff + RW'(1)) == want_ff) begin
                  state_in = S_IDLE;
               end
            end
         end

         S_TICK_RD: begin
            if (alive_ff[ptr_ff]) begin
               state_in = S_TICK_WR;
            end else if (ptr_last) begin
               state_in = S_TICK_DONE;
            end else begin
               ptr_in = ptr_wrap;
            end
         end

         S_TICK_WR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = age_next;
            if (age_next > dl_ff) begin
               alive_in[ptr_ff]  = 1'b0;
               failed_in[ptr_ff] = 1'b1;
               live_cnt_in       = live_cnt_ff - CW'(1);
            end
            ptr_in   = ptr_wrap;
            state_in = ptr_last ? S_TICK_DONE : S_TICK_RD;
         end

         S_TICK_DONE: begin
            if (failed_ff == '0) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_NONE_FAILED;
                  rsp_node_in   = 4'd0;
                  rsp_rank_in   = 3'd0;
                  rsp_live_in   = 5'(live_cnt_ff);
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               ptr_in      = '0;
               emit_cnt_in = 4'd0;
               state_in    = S_TICK_EMIT;
            end
         end

         // failed nodes in ascending id, at most sixteen beats
         S_TICK_EMIT: begin
            if (!failed_ff[ptr_ff]) begin
               ptr_in = ptr_wrap;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_node_in   = 4'(ptr_ff);
               rsp_rank_in   = 3'd0;
               rsp_live_in   = 5'(live_cnt_ff);
               rsp_last_in   = !more_failed || (emit_cnt_ff == 4'(RESULT_CAP - 1));
               emit_cnt_in   = emit_cnt_ff + 4'd1;
               ptr_in        = ptr_wrap;
               if (!more_failed || (emit_cnt_ff == 4'(RESULT_CAP - 1))) begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         alive_ff     <= '0;
         failed_ff    <= '0;
         live_cnt_ff  <= '0;
         next_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         skip_ff      <= '0;
         rank_ff      <= '0;
         want_ff      <= '0;
         emit_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         alive_ff     <= alive_in;
         failed_ff    <= failed_in;
         live_cnt_ff  <= live_cnt_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
         skip_ff      <= skip_in;
         rank_ff      <= rank_in;
         want_ff      <= want_in;
         emit_cnt_ff  <= emit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_live_ff   <= rsp_live_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // ages are only read for live nodes, and a node goes live with its age written
   always_ff @(posedge clock) begin
      if (mem_we) begin
         age_mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= age_mem[mem_raddr];
   end

   rpl_divmod #(
      .DW (KEY_W),
      .VW (CW)
   ) u_divmod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_key),
      .divisor   (live_cnt_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_live_ff, rsp_rank_ff, rsp_node_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_live_count_matches: assert property (@(posedge clock) disable iff (reset)
      live_cnt_ff == CW'($countones(alive_ff)))
      else $error("live count out of step with alive bits");

   a_live_below_issued: assert property (@(posedge clock) disable iff (reset)
      live_cnt_ff <= next_free_ff)
      else $error("more live nodes than ids handed out");

   a_walk_has_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV || state_ff == S_WALK) |-> live_cnt_ff != '0)
      else $error("placement running with no live node");

   a_failed_not_alive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TICK_EMIT && failed_ff[ptr_ff]) |-> !alive_ff[ptr_ff])
      else $error("failed node still marked alive");

endmodule

>>> tb/sv/tb_replica_placement_with_liveness_unit.sv
`timescale 1ns / 1ps

module tb_replica_placement_with_liveness_unit;
   import rpl_pkg::*;

   localparam int NODES    = MAX_NODES;
   localparam int REPLICAS = MAX_REPLICAS;

   typedef struct {
      status_type status;
      logic [3:0] node;
      logic [2:0] rank;
      logic [4:0] live;
      logic       last;
   } beat_type;

   // mirrors the node table and holds the beats still owed by the block
   class placement_tracker_type;
      bit          alive[NODES];
      bit [7:0]    age[NODES];
      int unsigned next_id;
      bit [3:0]    repl_factor;
      bit [7:0]    dead_limit;
      beat_type    pending_beats[$];
      int          errors;

      function new();
         foreach (alive[i]) begin
            alive[i] = 1'b0;
            age[i]   = 8'd0;
         end
         next_id     = 0;
         repl_factor = RF_RST;
         dead_limit  = DL_RST;
         errors      = 0;
      endfunction

      function int unsigned live_nodes();
         int unsigned n;
         n = 0;
         foreach (alive[i]) if (alive[i]) n++;
         return n;
      endfunction

      function void add_beat(status_type st, int unsigned node, int unsigned rank,
                             int unsigned live, bit last);
         beat_type b;
         b.status = st;
         b.node   = node[3:0];
         b.rank   = rank[2:0];
         b.live   = live[4:0];
         b.last   = last;
         pending_beats.insert(pending_beats.size(), b);
      endfunction

      function void note_request(action_type act, logic [3:0] nid, logic [31:0] key);
         int unsigned live, want, start, n_fail, seen;
         int unsigned ids[NODES];
         bit failed[NODES];
         case (act)
            ACT_REGISTER: begin
               if (next_id >= NODES) begin
                  add_beat(STAT_FULL, 0, 0, live_nodes(), 1'b1);
               end else begin
                  alive[next_id] = 1'b1;
                  age[next_id]   = 8'd0;
                  next_id++;
                  add_beat(STAT_OK, next_id - 1, 0, live_nodes(), 1'b1);
               end
            end
            ACT_HEARTBEAT: begin
               if (alive[nid]) age[nid] = 8'd0;
               add_beat(STAT_OK, 32'(nid), 0, live_nodes(), 1'b1);
            end
            ACT_TICK: begin
               n_fail = 0;
               for (int i = 0; i < NODES; i++) begin
                  failed[i] = 1'b0;
                  if (alive[i]) begin
                     if (age[i] != AGE_MAX) age[i]++;
                     if (age[i] > dead_limit) begin
                        alive[i]  = 1'b0;
                        failed[i] = 1'b1;
                        n_fail++;
                     end
                  end
               end
               live = live_nodes();
               seen = 0;
               for (int i = 0; i < NODES; i++) begin
                  if (failed[i]) begin
                     seen++;
                     add_beat(STAT_OK, i, 0, live, seen == n_fail);
                  end
               end
               if (n_fail == 0) add_beat(STAT_NONE_FAILED, 0, 0, live, 1'b1);
            end
            ACT_PLACE: begin
               live = 0;
               for (int i = 0; i < NODES; i++) begin
                  if (alive[i]) begin
                     ids[live] = i;
                     live++;
                  end
               end
               if (live == 0) begin
                  add_beat(STAT_NO_LIVE, 0, 0, 0, 1'b1);
               end else begin
                  want = (repl_factor == 0) ? 1 : 32'(repl_factor);
                  if (want > live) want = live;
                  if (want > REPLICAS) want = REPLICAS;
                  start = key % live;
                  for (int unsigned r = 0; r < want; r++)
                     add_beat(STAT_OK, ids[(start + r) % live], r, live, r + 1 == want);
               end
            end
         endcase
      endfunction

      function void compare_field(string name, logic [4:0] want, logic [4:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [1:0] st, logic [3:0] node, logic [2:0] rank,
                                   logic [4:0] live, logic last);
         beat_type exp;
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got status %0d node %0d",
                     $time, st, node, " rank %0d live %0d last %0d", rank, live, last);
            errors++;
            return;
         end
         exp = pending_beats.pop_front();
         compare_field("status", 5'(exp.status), 5'(st));
         compare_field("result_node", 5'(exp.node), 5'(node));
         compare_field("replica_rank", 5'(exp.rank), 5'(rank));
         compare_field("live_count", exp.live, live);
         compare_field("is_last", 5'(exp.last), 5'(last));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   placement_tracker_type sb;
   bit quiet_send = 1'b0;
   bit quiet_recv = 1'b0;
   int stall_left = 0;

   replica_placement_with_liveness_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always #5 clock = ~clock;

   // receiver back-pressure, with quiet stretches now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if ($urandom_range(0, 399) == 0) quiet_recv = !quiet_recv;
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet_recv && $urandom_range(0, 9) < 3) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tuser, rsp_tdata[3:0], rsp_tdata[6:4], rsp_tdata[11:7],
                           rsp_tlast);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_send || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_req(action_type act, logic [3:0] nid, logic [31:0] key);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {4'b0, key, nid};
      do @(posedge clock); while (!req_tready);
      sb.note_request(act, nid, key);
   endtask

   // drain all owed beats, then allow for a tick walk still in progress
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending_beats.size() != 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(logic regsel, logic [31:0] value);
      wait_idle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {regsel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (regsel == REG_REPL_FACTOR) sb.repl_factor = value[3:0];
      else sb.dead_limit = value[7:0];
   endtask

   task automatic random_item(int unsigned target_live);
      int r;
      int unsigned lc;
      logic [3:0]  nid;
      logic [31:0] key;
      action_type  act;
      r   = $urandom_range(0, 99);
      lc  = sb.live_nodes();
      nid = 4'($urandom_range(0, 15));
      key = $urandom;
      if (r < 3 || (r < 30 && lc < target_live && sb.next_id < NODES)) begin
         act = ACT_REGISTER;
      end else if (r < 50) begin
         act = ACT_HEARTBEAT;
         // mostly keep live nodes going, sometimes poke a dead or unused id
         if (lc > 0 && $urandom_range(0, 9) > 1)
            do nid = 4'($urandom_range(0, 15)); while (!sb.alive[nid]);
      end else if (r < 82) begin
         act = ACT_PLACE;
         case ($urandom_range(0, 19))
            0:       key = 32'h0000_0000;
            1:       key = 32'hffff_ffff;
            default: ;
         endcase
      end else begin
         act = ACT_TICK;
      end
      send_req(act, nid, key);
   endtask

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty table, default settings
      send_req(ACT_PLACE, 4'd0, 32'h0000_0000);
      send_req(ACT_TICK, 4'd9, 32'h1234_5678);
      send_req(ACT_HEARTBEAT, 4'd0, 32'h0);
      send_req(ACT_HEARTBEAT, 4'd15, 32'hffff_ffff);
      repeat (3) send_req(ACT_REGISTER, 4'd7, 32'h0);
      send_req(ACT_PLACE, 4'd0, 32'h0000_0000);
      send_req(ACT_PLACE, 4'd15, 32'hffff_ffff);
      send_req(ACT_PLACE, 4'd3, 32'h5555_5555);
      send_req(ACT_HEARTBEAT, 4'd2, 32'h0);
      send_req(ACT_TICK, 4'd0, 32'h0);

      // replica list capped by live count, two nodes fail in one tick
      csr_write(REG_REPL_FACTOR, 32'd8);
      csr_write(REG_DEAD_LIMIT, 32'd1);
      send_req(ACT_PLACE, 4'd0, 32'haaaa_aaaa);
      send_req(ACT_HEARTBEAT, 4'd1, 32'h0);
      send_req(ACT_TICK, 4'd0, 32'h0);
      send_req(ACT_PLACE, 4'd0, 32'h0000_0007);

      // zero replication factor acts as one, zero dead limit fails everyone
      csr_write(REG_REPL_FACTOR, 32'd0);
      csr_write(REG_DEAD_LIMIT, 32'd0);
      send_req(ACT_REGISTER, 4'd0, 32'h0);
      send_req(ACT_PLACE, 4'd0, 32'd123);
      send_req(ACT_TICK, 4'd0, 32'h0);
      send_req(ACT_PLACE, 4'd0, 32'hdead_beef);

      csr_write(REG_REPL_FACTOR, 32'd3);
      csr_write(REG_DEAD_LIMIT, 32'd6);
      repeat (35) random_item(3);

      quiet_send = 1'b1;
      csr_write(REG_REPL_FACTOR, 32'd0);
      csr_write(REG_DEAD_LIMIT, 32'd2);
      repeat (30) random_item(3);
      quiet_send = 1'b0;

      // fill the table with the limit out of reach, then age it with a run of ticks
      csr_write(REG_REPL_FACTOR, 32'd8);
      csr_write(REG_DEAD_LIMIT, 32'd255);
      repeat (30) random_item(NODES);
      repeat (60) begin
         if ($urandom_range(0, 7) == 0)
            send_req(ACT_PLACE, 4'($urandom_range(0, 15)), $urandom);
         else
            send_req(ACT_TICK, 4'($urandom_range(0, 15)), $urandom);
      end

      csr_write(REG_REPL_FACTOR, 32'd15);
      csr_write(REG_DEAD_LIMIT, 32'd254);
      repeat (25) random_item(NODES);

      // use up every id, overflow the registry, then fail what is left
      csr_write(REG_REPL_FACTOR, 32'd1);
      csr_write(REG_DEAD_LIMIT, 32'd0);
      while (sb.next_id < NODES)
         send_req(ACT_REGISTER, 4'($urandom_range(0, 15)), $urandom);
      send_req(ACT_PLACE, 4'd0, 32'hffff_ffff);
      send_req(ACT_REGISTER, 4'd0, 32'h0);
      send_req(ACT_REGISTER, 4'd15, 32'hffff_ffff);
      send_req(ACT_TICK, 4'd0, 32'h0);
      send_req(ACT_PLACE, 4'd0, 32'h0);

      wait_idle();
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
